>>> rtl/core/vtsp_pkg.sv
// ----------------------------------------------------------------------------
// vtsp_pkg
// Shared types and constants of the tagged-value stream parser: codes,
// channel payloads and the command and status bundles of the core.
// ----------------------------------------------------------------------------
`default_nettype none

package vtsp_pkg;

   // Sizing of the frame stack and of container counts
   localparam int STACK_DEPTH = 64;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int OPEN_W      = 7;
   localparam int COUNT_WIDTH = 32;
   localparam int FRAME_W     = COUNT_WIDTH + 2;
   localparam logic [64:0] COUNT_CAP_WIDE = (65'd1 << COUNT_WIDTH) - 65'd1;
   localparam logic [63:0] COUNT_CAP = COUNT_CAP_WIDE[63:0];

   // Encoding constants
   localparam logic [3:0] VARINT_MAX = 4'd10;
   localparam logic [3:0] VARINT_LAST = 4'd9;
   localparam logic [2:0] HDR_LAST = 3'd5;
   localparam logic [2:0] HDR_VERSION = 3'd4;
   localparam logic [2:0] FLOAT_LAST = 3'd7;

   // Tag bytes
   localparam logic [7:0] TAG_NULL   = 8'h00;
   localparam logic [7:0] TAG_FALSE  = 8'h01;
   localparam logic [7:0] TAG_TRUE   = 8'h02;
   localparam logic [7:0] TAG_INT    = 8'h03;
   localparam logic [7:0] TAG_FLOAT  = 8'h04;
   localparam logic [7:0] TAG_STR    = 8'h05;
   localparam logic [7:0] TAG_BYTES  = 8'h06;
   localparam logic [7:0] TAG_LIST   = 8'h07;
   localparam logic [7:0] TAG_DICT   = 8'h08;
   localparam logic [7:0] TAG_TAGGED = 8'h09;
   localparam logic [7:0] TAG_TUPLE  = 8'h0A;

   // Token kinds
   localparam logic [3:0] KIND_INT   = 4'd3;
   localparam logic [3:0] KIND_FLOAT = 4'd4;
   localparam logic [3:0] KIND_STR   = 4'd5;
   localparam logic [3:0] KIND_BYTES = 4'd6;
   localparam logic [3:0] KIND_LIST  = 4'd7;
   localparam logic [3:0] KIND_DICT  = 4'd8;
   localparam logic [3:0] KIND_TAG   = 4'd9;
   localparam logic [3:0] KIND_TUPLE = 4'd10;
   localparam logic [3:0] KIND_KEY   = 4'd11;
   localparam logic [3:0] KIND_BYTE  = 4'd12;
   localparam logic [3:0] KIND_NONE  = 4'd13;

   // Parse status
   localparam logic [2:0] ST_RUN   = 3'd0;
   localparam logic [2:0] ST_DONE  = 3'd1;
   localparam logic [2:0] ST_TRUNC = 3'd2;
   localparam logic [2:0] ST_ERR   = 3'd3;
   localparam logic [2:0] ST_HDR   = 3'd4;

   // What a varint is read for
   localparam logic [2:0] P_INT    = 3'd0;
   localparam logic [2:0] P_STR    = 3'd1;
   localparam logic [2:0] P_BYTES  = 3'd2;
   localparam logic [2:0] P_LIST   = 3'd3;
   localparam logic [2:0] P_DICT   = 3'd4;
   localparam logic [2:0] P_TAGGED = 3'd5;
   localparam logic [2:0] P_TUPLE  = 3'd6;
   localparam logic [2:0] P_KEY    = 3'd7;

   // Frame kinds
   localparam logic [1:0] FR_LIST   = 2'd0;
   localparam logic [1:0] FR_DICT   = 2'd1;
   localparam logic [1:0] FR_TAGGED = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_MAGIC   = 3'd0;
   localparam logic [2:0] REG_VERSION = 3'd1;
   localparam logic [2:0] REG_LIST    = 3'd2;
   localparam logic [2:0] REG_DICT    = 3'd3;
   localparam logic [2:0] REG_TEXT    = 3'd4;
   localparam logic [2:0] REG_BLOB    = 3'd5;
   localparam logic [2:0] REG_NEST    = 3'd6;

   typedef enum logic [2:0] {
      TV_ZERO,
      TV_BYTE,
      TV_ZIGZAG,
      TV_VARINT,
      TV_FLOAT,
      TV_TAG
   } tval_sel_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [63:0] token_value;
      logic [6:0]  nesting_depth;
      logic [2:0]  status;
   } rsp_payload_type;

   typedef struct packed {
      logic         latch;
      logic         restart;
      logic         hdr_step;
      logic         acc_clr;
      logic         purpose_wr;
      logic [2:0]   purpose;
      logic         var_take;
      logic         flt_take;
      logic         pay_load;
      logic         pay_dec;
      logic         tok_wr;
      logic [3:0]   tok_kind;
      tval_sel_type tok_sel;
      logic         push;
      logic [1:0]   push_kind;
      logic         top_dec;
      logic         pop;
      logic         pop_load;
      logic         emit;
      logic [2:0]   emit_status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic [2:0] hdr_idx;
      logic       hdr_bad_next;
      logic [2:0] purpose;
      logic [3:0] vlen;
      logic       var_zero;
      logic       over_text;
      logic       over_blob;
      logic       over_list;
      logic       over_dict;
      logic       depth_err;
      logic       stack_full;
      logic       open_zero;
      logic       open_one;
      logic       top_last;
      logic [1:0] top_kind;
      logic       pay_last;
      logic       out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/core/vtsp_datapath.sv
// ----------------------------------------------------------------------------
// vtsp_datapath
// Registers, varint and float assembly, limit checks, frame stack with a
// cached top frame, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsp_datapath
   import vtsp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_stall,
   output      logic            rsp_valid,
   output      rsp_payload_type rsp_payload,
   input  wire logic            csr_we,
   input  wire logic [2:0]      csr_index,
   input  wire logic [31:0]     csr_wdata,
   input  wire ctrl_cmd_type    cmd,
   output      dp_stat_type     stat
);

   logic [31:0] magic_ff, list_max_ff, dict_max_ff, text_max_ff, blob_max_ff;
   logic [7:0]  version_ff;
   logic [6:0]  nest_max_ff;

   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [2:0]  hdr_idx_ff;
   logic        hdr_bad_ff;
   logic [63:0] acc_ff;
   logic [3:0]  vlen_ff;
   logic [2:0]  purpose_ff;
   logic [COUNT_WIDTH-1:0] pay_ff;
   logic [OPEN_W-1:0] open_ff;
   logic [COUNT_WIDTH-1:0] top_left_ff;
   logic [1:0]  top_kind_ff;
   logic [FRAME_W-1:0] mem_rd_ff;
   logic [FRAME_W-1:0] frame_mem [STACK_DEPTH];
   logic [3:0]  tok_kind_ff;
   logic [63:0] tok_val_ff;
   logic [OPEN_W-1:0] depth_ff;
   logic        rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   logic [7:0]  want;
   logic [6:0]  vshift;
   logic [70:0] grp;
   logic [63:0] var_new, flt_new, zigzag, tok_val_in;
   logic [63:0] list_lim, dict_lim;
   logic [OPEN_W-1:0] nest_lim, open_m1, open_m2;
   logic [COUNT_WIDTH-1:0] pay_next, push_count;

   // Expected header byte
   always_comb begin
      if (hdr_idx_ff < HDR_VERSION) begin
         want = 8'(magic_ff >> {hdr_idx_ff[1:0], 3'b000});
      end else if (hdr_idx_ff == HDR_VERSION) begin
         want = version_ff;
      end else begin
         want = byte_ff;
      end
   end

   // Assemble varint group and float byte
   assign vshift  = 7'({vlen_ff, 3'b000}) - 7'(vlen_ff);
   assign grp     = 71'(byte_ff[6:0]) << vshift;
   assign var_new = acc_ff | ((vlen_ff < VARINT_MAX) ? grp[63:0] : 64'd0);
   assign flt_new = acc_ff | (64'(byte_ff) << {vlen_ff[2:0], 3'b000});
   assign zigzag  = {1'b0, var_new[63:1]} ^ {64{var_new[0]}};

   // Limits
   assign list_lim = (64'(list_max_ff) > COUNT_CAP) ? COUNT_CAP : 64'(list_max_ff);
   assign dict_lim = (64'(dict_max_ff) > COUNT_CAP) ? COUNT_CAP : 64'(dict_max_ff);
   assign nest_lim = (nest_max_ff > OPEN_W'(STACK_DEPTH)) ? OPEN_W'(STACK_DEPTH)
                                                          : nest_max_ff;
   assign open_m1  = open_ff - OPEN_W'(1);
   assign open_m2  = open_ff - OPEN_W'(2);
   assign pay_next = pay_ff - COUNT_WIDTH'(1);
   assign push_count = (cmd.push_kind == FR_TAGGED) ? COUNT_WIDTH'(1)
                                                    : var_new[COUNT_WIDTH-1:0];

   always_comb begin
      unique case (cmd.tok_sel)
         TV_ZERO:   tok_val_in = 64'd0;
         TV_BYTE:   tok_val_in = 64'(byte_ff);
         TV_ZIGZAG: tok_val_in = zigzag;
         TV_VARINT: tok_val_in = var_new;
         TV_FLOAT:  tok_val_in = flt_new;
         TV_TAG:    tok_val_in = {32'd0, var_new[31:0]};
         default:   tok_val_in = 64'd0;
      endcase
   end

   // Status towards the controller
   always_comb begin
      stat.data_byte    = byte_ff;
      stat.last         = last_ff;
      stat.hdr_idx      = hdr_idx_ff;
      stat.hdr_bad_next = hdr_bad_ff | (byte_ff != want);
      stat.purpose      = purpose_ff;
      stat.vlen         = vlen_ff;
      stat.var_zero     = (var_new == 64'd0);
      stat.over_text    = (var_new > 64'(text_max_ff));
      stat.over_blob    = (var_new > 64'(blob_max_ff));
      stat.over_list    = (var_new > list_lim);
      stat.over_dict    = (var_new > dict_lim);
      stat.depth_err    = (open_ff >= nest_lim);
      stat.stack_full   = (open_ff >= OPEN_W'(STACK_DEPTH));
      stat.open_zero    = (open_ff == '0);
      stat.open_one     = (open_ff == OPEN_W'(1));
      stat.top_last     = (top_left_ff == COUNT_WIDTH'(1));
      stat.top_kind     = top_kind_ff;
      stat.pay_last     = (pay_next == '0);
      stat.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff    <= '0;
         version_ff  <= '0;
         list_max_ff <= '1;
         dict_max_ff <= '1;
         text_max_ff <= '1;
         blob_max_ff <= '1;
         nest_max_ff <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAGIC:   magic_ff    <= csr_wdata;
            REG_VERSION: version_ff  <= csr_wdata[7:0];
            REG_LIST:    list_max_ff <= csr_wdata;
            REG_DICT:    dict_max_ff <= csr_wdata;
            REG_TEXT:    text_max_ff <= csr_wdata;
            REG_BLOB:    blob_max_ff <= csr_wdata;
            REG_NEST:    nest_max_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Parse state registers
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         hdr_idx_ff <= '0;
         hdr_bad_ff <= 1'b0;
         acc_ff     <= '0;
         vlen_ff    <= '0;
         purpose_ff <= '0;
         pay_ff     <= '0;
         open_ff    <= '0;
      end else begin
         if (cmd.hdr_step) begin
            hdr_bad_ff <= stat.hdr_bad_next;
            if (hdr_idx_ff < HDR_LAST) hdr_idx_ff <= hdr_idx_ff + 3'd1;
         end
         if (cmd.acc_clr) begin
            acc_ff  <= '0;
            vlen_ff <= '0;
         end else if (cmd.var_take) begin
            acc_ff  <= var_new;
            vlen_ff <= vlen_ff + 4'd1;
         end else if (cmd.flt_take) begin
            acc_ff  <= flt_new;
            vlen_ff <= vlen_ff + 4'd1;
         end
         if (cmd.purpose_wr) purpose_ff <= cmd.purpose;
         if (cmd.pay_load) begin
            pay_ff <= var_new[COUNT_WIDTH-1:0];
         end else if (cmd.pay_dec) begin
            pay_ff <= pay_next;
         end
         if (cmd.push) begin
            open_ff <= open_ff + OPEN_W'(1);
         end else if (cmd.pop) begin
            open_ff <= open_m1;
         end
      end
   end

   // Frame stack: memory below a cached top frame
   always_ff @(posedge clock) begin
      if (cmd.push && !stat.open_zero) begin
         frame_mem[open_m1[SP_W-1:0]] <= {top_kind_ff, top_left_ff};
      end
      if (cmd.pop) mem_rd_ff <= frame_mem[open_m2[SP_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         top_kind_ff <= cmd.push_kind;
         top_left_ff <= push_count;
      end else if (cmd.pop_load) begin
         {top_kind_ff, top_left_ff} <= mem_rd_ff;
      end else if (cmd.top_dec) begin
         top_left_ff <= top_left_ff - COUNT_WIDTH'(1);
      end
   end

   // Input byte and token registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         byte_ff     <= req_payload.data_byte;
         last_ff     <= req_payload.end_of_buffer;
         depth_ff    <= open_ff;
         tok_kind_ff <= KIND_NONE;
         tok_val_ff  <= '0;
      end else if (cmd.tok_wr) begin
         tok_kind_ff <= cmd.tok_kind;
         tok_val_ff  <= tok_val_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff.token_kind    <= tok_kind_ff;
         rsp_data_ff.token_value   <= tok_val_ff;
         rsp_data_ff.nesting_depth <= depth_ff;
         rsp_data_ff.status        <= cmd.emit_status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/vtsp_ctrl.sv
// ----------------------------------------------------------------------------
// vtsp_ctrl
// Parse controller: header, tag, varint, float and payload phases, the
// container close sequence and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vtsp_ctrl
   import vtsp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire dp_stat_type  stat,
   output      ctrl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_FIN, S_POPLD, S_BEGIN, S_END
   } state_type;

   typedef enum logic [2:0] {
      PH_HEADER, PH_TAG, PH_VARINT, PH_FLOAT, PH_PAYLOAD
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      skip_ff, skip_in;
   logic      tok_ff, tok_in;
   logic [2:0] st_ff, st_in;
   logic [2:0] st_final;
   logic       need_emit;

   assign st_final  = (st_ff == ST_RUN && stat.last) ? ST_TRUNC : st_ff;
   assign need_emit = tok_ff || (st_final != ST_RUN);

   always_comb begin
      cmd      = '0;
      cmd.tok_sel = TV_ZERO;
      state_in = state_ff;
      phase_in = phase_ff;
      skip_in  = skip_ff;
      tok_in   = tok_ff;
      st_in    = st_ff;

      unique case (state_ff)
         // Take a byte
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               tok_in    = 1'b0;
               st_in     = ST_RUN;
               state_in  = S_EXEC;
            end
         end

         // Work on the byte by phase
         S_EXEC: begin
            state_in = S_END;
            if (skip_ff) begin
               state_in = S_IDLE;
               if (stat.last) begin
                  cmd.restart = 1'b1;
                  phase_in    = PH_HEADER;
                  skip_in     = 1'b0;
               end
            end else begin
               unique case (phase_ff)
                  PH_HEADER: begin
                     cmd.hdr_step = 1'b1;
                     if (stat.hdr_idx == HDR_LAST) begin
                        if (stat.hdr_bad_next) st_in = ST_HDR;
                        else state_in = S_BEGIN;
                     end
                  end
                  PH_TAG: begin
                     cmd.acc_clr = 1'b1;
                     phase_in    = PH_VARINT;
                     unique case (stat.data_byte)
                        TAG_NULL, TAG_FALSE, TAG_TRUE: begin
                           cmd.tok_wr   = 1'b1;
                           cmd.tok_kind = stat.data_byte[3:0];
                           tok_in       = 1'b1;
                           phase_in     = phase_ff;
                           state_in     = S_FIN;
                        end
                        TAG_INT: begin
                           cmd.purpose_wr = 1'b1;
                           cmd.purpose    = P_INT;
                        end
                        TAG_FLOAT:  phase_in = PH_FLOAT;
                        TAG_STR: begin
                           cmd.purpose_wr = 1'b1;
                           cmd.purpose    = P_STR;
                        end
                        TAG_BYTES: begin
                           cmd.purpose_wr = 1'b1;
                           cmd.purpose    = P_BYTES;
                        end
                        TAG_LIST: begin
                           cmd.purpose_wr = 1'b1;
                           cmd.purpose    = P_LIST;
                        end
                        TAG_DICT: begin
                           cmd.purpose_wr = 1'b1;
                           cmd.purpose    = P_DICT;
                        end
                        TAG_TAGGED: begin
                           cmd.purpose_wr = 1'b1;
                           cmd.purpose    = P_TAGGED;
                        end
                        TAG_TUPLE: begin
                           cmd.purpose_wr = 1'b1;
                           cmd.purpose    = P_TUPLE;
                        end
                        default: begin
                           cmd.acc_clr = 1'b0;
                           phase_in    = phase_ff;
                           st_in       = ST_ERR;
                        end
                     endcase
                  end
                  PH_VARINT: begin
                     cmd.var_take = 1'b1;
                     if (stat.data_byte[7]) begin
                        if (stat.vlen == VARINT_LAST) st_in = ST_ERR;
                     end else begin
                        cmd.tok_sel = TV_VARINT;
                        unique case (stat.purpose)
                           P_INT: begin
                              cmd.tok_wr   = 1'b1;
                              cmd.tok_kind = KIND_INT;
                              cmd.tok_sel  = TV_ZIGZAG;
                              tok_in       = 1'b1;
                              state_in     = S_FIN;
                           end
                           P_STR, P_BYTES, P_KEY: begin
                              if ((stat.purpose == P_BYTES) ? stat.over_blob
                                                            : stat.over_text) begin
                                 st_in = ST_ERR;
                              end else begin
                                 cmd.tok_wr   = 1'b1;
                                 cmd.tok_kind = (stat.purpose == P_STR) ? KIND_STR :
                                                (stat.purpose == P_BYTES) ? KIND_BYTES
                                                                          : KIND_KEY;
                                 tok_in       = 1'b1;
                                 if (stat.var_zero) begin
                                    state_in = (stat.purpose == P_KEY) ? S_BEGIN : S_FIN;
                                 end else begin
                                    cmd.pay_load = 1'b1;
                                    phase_in     = PH_PAYLOAD;
                                 end
                              end
                           end
                           P_LIST, P_TUPLE, P_DICT: begin
                              if ((stat.purpose == P_DICT) ? stat.over_dict
                                                           : stat.over_list) begin
                                 st_in = ST_ERR;
                              end else begin
                                 cmd.tok_wr   = 1'b1;
                                 cmd.tok_kind = (stat.purpose == P_LIST) ? KIND_LIST :
                                                (stat.purpose == P_DICT) ? KIND_DICT
                                                                         : KIND_TUPLE;
                                 tok_in       = 1'b1;
                                 if (stat.var_zero) begin
                                    state_in = S_FIN;
                                 end else if (stat.stack_full) begin
                                    st_in = ST_ERR;
                                 end else if (stat.purpose == P_DICT) begin
                                    cmd.push       = 1'b1;
                                    cmd.push_kind  = FR_DICT;
                                    cmd.acc_clr    = 1'b1;
                                    cmd.purpose_wr = 1'b1;
                                    cmd.purpose    = P_KEY;
                                 end else begin
                                    cmd.push      = 1'b1;
                                    cmd.push_kind = FR_LIST;
                                    state_in      = S_BEGIN;
                                 end
                              end
                           end
                           default: begin
                              cmd.tok_wr   = 1'b1;
                              cmd.tok_kind = KIND_TAG;
                              cmd.tok_sel  = TV_TAG;
                              tok_in       = 1'b1;
                              if (stat.stack_full) begin
                                 st_in = ST_ERR;
                              end else begin
                                 cmd.push      = 1'b1;
                                 cmd.push_kind = FR_TAGGED;
                                 state_in      = S_BEGIN;
                              end
                           end
                        endcase
                     end
                  end
                  PH_FLOAT: begin
                     cmd.flt_take = 1'b1;
                     if (stat.vlen[2:0] == FLOAT_LAST) begin
                        cmd.tok_wr   = 1'b1;
                        cmd.tok_kind = KIND_FLOAT;
                        cmd.tok_sel  = TV_FLOAT;
                        tok_in       = 1'b1;
                        state_in     = S_FIN;
                     end
                  end
                  PH_PAYLOAD: begin
                     cmd.pay_dec  = 1'b1;
                     cmd.tok_wr   = 1'b1;
                     cmd.tok_kind = KIND_BYTE;
                     cmd.tok_sel  = TV_BYTE;
                     tok_in       = 1'b1;
                     if (stat.pay_last) begin
                        state_in = (stat.purpose == P_KEY) ? S_BEGIN : S_FIN;
                     end
                  end
                  default: st_in = ST_ERR;
               endcase
            end
         end

         // Count down the top frame, closing finished containers
         S_FIN: begin
            if (stat.open_zero) begin
               st_in    = ST_DONE;
               state_in = S_END;
            end else if (stat.top_last) begin
               cmd.pop  = 1'b1;
               state_in = stat.open_one ? S_FIN : S_POPLD;
            end else begin
               cmd.top_dec = 1'b1;
               if (stat.top_kind == FR_DICT) begin
                  cmd.acc_clr    = 1'b1;
                  cmd.purpose_wr = 1'b1;
                  cmd.purpose    = P_KEY;
                  phase_in       = PH_VARINT;
                  state_in       = S_END;
               end else begin
                  state_in = S_BEGIN;
               end
            end
         end

         // Restore the frame below
         S_POPLD: begin
            cmd.pop_load = 1'b1;
            state_in     = S_FIN;
         end

         // A value is due: check depth
         S_BEGIN: begin
            if (stat.depth_err) st_in = ST_ERR;
            else phase_in = PH_TAG;
            state_in = S_END;
         end

         // Hand the result over and close the byte
         S_END: begin
            if (!need_emit || stat.out_free) begin
               cmd.emit        = need_emit;
               cmd.emit_status = st_final;
               state_in        = S_IDLE;
               if (st_final != ST_RUN) begin
                  if (stat.last) begin
                     cmd.restart = 1'b1;
                     phase_in    = PH_HEADER;
                  end else begin
                     skip_in = 1'b1;
                  end
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and registered control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_HEADER;
         skip_ff  <= 1'b0;
         tok_ff   <= 1'b0;
         st_ff    <= ST_RUN;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         skip_ff  <= skip_in;
         tok_ff   <= tok_in;
         st_ff    <= st_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/varint_tlv_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// varint_tlv_stream_parser_unit
// Byte-stream parser for a header-checked, tagged zigzag-varint encoding;
// one token per recognised item or payload byte.
//
//   channel  ports                         direction
//   req      req_valid/req_stall/payload   in : one buffer byte
//   rsp      rsp_valid/rsp_stall/payload   out: token and status
//   csr      csr_we/csr_index/csr_wdata    in : register write
//
// Each container closed on the way pops its frame; unless it was the last
// one open, the frame below is read from the single-port frame stack.
// Bytes in the skip region after an end of parse yield no result.
// Reset is synchronous and needs no clearing pass; frames are read only
// after being pushed. A stalled result holds until taken; the next byte is
// accepted meanwhile and waits at hand-off only if it also has a result.
// ----------------------------------------------------------------------------
`default_nettype none

module varint_tlv_stream_parser_unit
   import vtsp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload,
   input  wire logic            csr_we,
   input  wire logic [2:0]      csr_index,
   input  wire logic [31:0]     csr_wdata
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Control
   vtsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath
   vtsp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

`default_nettype wire
